// File: src/sha_pkg.sv
// shared types, constants and round functions for the sha-256 byte stream hasher
package sha_pkg;

  // byte source for the block shift register
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       shift_en;
    logic [1:0] byte_src;
    logic [2:0] len_idx;
    logic       add_bits;
    logic       load_work;
    logic       round_en;
    logic [5:0] round;
    logic       add_hash;
    logic       init_hash;
    logic [2:0] out_idx;
  } cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: src/sha_ctrl.sv
// controller state machine: byte loading, padding, round sequencing and digest output
module sha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_present,
  input  logic          in_end,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_last,
  output sha_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] round, round_next;
  logic [2:0] out_idx, out_idx_next;
  logic       pend_end, pend_end_next;
  logic       padding, padding_next;
  logic       first, first_next;
  logic       final_blk, final_blk_next;

  logic in_acc, out_acc, len_zone;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  // positions 56..63 hold the length in the final block
  assign len_zone = (fill[5:3] == 3'b111);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    round_next     = round;
    out_idx_next   = out_idx;
    pend_end_next  = pend_end;
    padding_next   = padding;
    first_next     = first;
    final_blk_next = final_blk;

    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_OUT);
    out_last      = (out_idx == 3'd7);

    cmd           = '0;
    cmd.round     = round;
    cmd.out_idx   = out_idx;
    cmd.len_idx   = ~fill[2:0];
    cmd.byte_src  = sha_pkg::SRC_DATA;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_present) begin
            cmd.shift_en = 1'b1;
            cmd.add_bits = 1'b1;
            fill_next    = fill + 6'd1;
            if (fill == 6'd63) begin
              cmd.load_work = 1'b1;
              round_next    = '0;
              pend_end_next = in_end;
              state_next    = S_ROUND;
            end else if (in_end) begin
              padding_next = 1'b1;
              first_next   = 1'b1;
              state_next   = S_PAD;
            end
          end else if (in_end) begin
            padding_next = 1'b1;
            first_next   = 1'b1;
            state_next   = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (first) begin
          cmd.byte_src   = sha_pkg::SRC_PAD;
          first_next     = 1'b0;
          final_blk_next = !len_zone;
        end else if (final_blk && len_zone) begin
          cmd.byte_src = sha_pkg::SRC_LEN;
        end else begin
          cmd.byte_src = sha_pkg::SRC_ZERO;
        end
        fill_next = fill + 6'd1;
        if (fill == 6'd63) begin
          cmd.load_work = 1'b1;
          round_next    = '0;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_next   = round + 6'd1;
        if (round == 6'd63) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        if (padding) begin
          if (final_blk) begin
            out_idx_next = '0;
            state_next   = S_OUT;
          end else begin
            final_blk_next = 1'b1;
            state_next     = S_PAD;
          end
        end else if (pend_end) begin
          // byte and end arrived together on a full block
          pend_end_next = 1'b0;
          padding_next  = 1'b1;
          first_next    = 1'b1;
          state_next    = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            cmd.init_hash  = 1'b1;
            padding_next   = 1'b0;
            final_blk_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      round     <= '0;
      out_idx   <= '0;
      pend_end  <= 1'b0;
      padding   <= 1'b0;
      first     <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      round     <= round_next;
      out_idx   <= out_idx_next;
      pend_end  <= pend_end_next;
      padding   <= padding_next;
      first     <= first_next;
      final_blk <= final_blk_next;
    end
  end

endmodule

// File: src/sha_dp.sv
// datapath: block and schedule shift register, round unit, hash state and bit count
module sha_dp (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t cmd,
  input  logic [7:0]    data_byte,
  output logic [31:0]   digest_word
);

  // block bytes shift in at the bottom; the top word is the oldest schedule word
  logic [511:0]      blk;
  logic [7:0][31:0]  work;
  logic [7:0][31:0]  hash;
  logic [63:0]       bits;

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    unique case (cmd.byte_src)
      sha_pkg::SRC_DATA: byte_in = data_byte;
      sha_pkg::SRC_PAD:  byte_in = sha_pkg::PAD_BYTE;
      sha_pkg::SRC_ZERO: byte_in = '0;
      sha_pkg::SRC_LEN:  byte_in = bits[{cmd.len_idx, 3'b000} +: 8];
      default:           byte_in = '0;
    endcase
  end

  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign w_new = sha_pkg::small_sigma1(w14) + w9 + sha_pkg::small_sigma0(w1) + w0;

  assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + sha_pkg::big_sigma1(work[4]) + ch
             + sha_pkg::ROUND_K[cmd.round] + w0;
  assign t2  = sha_pkg::big_sigma0(work[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      work <= hash;
    end else if (cmd.round_en) begin
      work <= {work[6], work[5], work[4], work[3] + t1,
               work[2], work[1], work[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_hash) begin
      hash <= sha_pkg::H_INIT;
      bits <= '0;
    end else begin
      if (cmd.add_hash) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + work[i];
        end
      end
      if (cmd.add_bits) begin
        bits <= bits + sha_pkg::BITS_PER_BYTE;
      end
    end
  end

  assign digest_word = hash[cmd.out_idx];

endmodule

// File: src/sha256_byte_stream_hasher.sv
// sha-256 byte stream hasher top level: stream ports around controller and datapath
// one message byte is taken per cycle while a block fills; the 64th byte starts a
// compression of 64 rounds plus a hash update step, and input stalls until that block is done
// at end of message padding shifts in one byte per cycle (up to 8 + 64 bytes, one or two
// compressions), then eight digest words follow, one per cycle when taken
// reset: idle and ready, hash words at the initial values, bit count and fill level zero
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tlast    // last_word
);

  sha_pkg::cmd_t cmd;
  logic [31:0]   digest_word;

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_present (s_tuser),
    .in_end     (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_last   (m_tlast),
    .cmd        (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata),
    .digest_word (digest_word)
  );

  assign m_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule

// File: verif/testbench.sv
// self-checking testbench for the sha-256 byte stream hasher: random messages, digest scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int STREAM_ITEMS   = 310;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [63:0]  msg_bits;
    logic [7:0]   block [64];
    int unsigned  fill;
    digest_word_t digest_queue [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
      msg_bits = '0;
      fill = 0;
    endfunction

    function logic [31:0] rotate_right(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) begin
        sched[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
        s0 = rotate_right(sched[t-15], 7) ^ rotate_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
        s1 = rotate_right(sched[t-2], 17) ^ rotate_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
        sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotate_right(e, 6) ^ rotate_right(e, 11) ^ rotate_right(e, 25))
             + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + sched[t];
        t2 = (rotate_right(a, 2) ^ rotate_right(a, 13) ^ rotate_right(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // a full block is compressed as soon as its last byte lands
    function void absorb(logic [7:0] value);
      block[fill] = value;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_item(logic [7:0] data, logic present, logic eom);
      logic [63:0] length_bits;
      digest_word_t dw;
      if (present) begin
        msg_bits += 64'd8;
        absorb(data);
      end
      if (!eom) return;
      length_bits = msg_bits;
      absorb(8'h80);
      // runs through a second block when the pad byte lands past byte 55
      while (fill != 56) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(length_bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.index = 3'(i);
        dw.last = (i == 7);
        digest_queue.push_back(dw);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t dw;
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest transfer: expected none, actual word %h index %0d last %0b",
                 $time, word, index, last);
        mismatches++;
        return;
      end
      dw = digest_queue.pop_front();
      if (word !== dw.word) begin
        $display("%0t: digest_word mismatch: expected %h, actual %h", $time, dw.word, word);
        mismatches++;
      end
      if (index !== dw.index) begin
        $display("%0t: word_index mismatch: expected %0d, actual %0d", $time, dw.index, index);
        mismatches++;
      end
      if (last !== dw.last) begin
        $display("%0t: last_word mismatch: expected %0b, actual %0b", $time, dw.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return digest_queue.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] byte_present
  logic        s_tlast = 1'b0;    // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        m_tlast;           // last_word

  digest_scoreboard sb = new();
  int  stall_cycles = 0;
  int  stream_items = 0;
  bit  no_idle = 1'b0;

  sha256_byte_stream_hasher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_length();
    int lengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 8);
    if (r < 75) return lengths[$urandom_range(0, 9)];
    return $urandom_range(0, 140);
  endfunction

  task automatic send_item(logic [7:0] data, logic present, logic eom);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    if (present || eom) stream_items++;
  endtask

  task automatic send_message(int length, bit end_on_byte);
    for (int i = 0; i < length; i++) begin
      // now and then an item that carries nothing
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == length - 1));
    end
    if (!end_on_byte || length == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // digest sink with random back-pressure
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    int msg_len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // item with neither flag, then the empty message
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // byte and end in the same transfer
    send_item(8'h00, 1'b1, 1'b1);
    // end with no byte after one byte, with an empty item between
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
    // two empty messages back to back
    send_item(8'h01, 1'b0, 1'b1);
    send_item(8'hfe, 1'b0, 1'b1);

    while (stream_items < STREAM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      msg_len = pick_length();
      // keep the last message within the item budget
      if (msg_len > STREAM_ITEMS - stream_items) msg_len = STREAM_ITEMS - stream_items;
      send_message(msg_len, 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sha256_byte_stream_hasher.f
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dp.sv
src/sha256_byte_stream_hasher.sv
verif/testbench.sv
